@@ src/kcp_pkg.sv @@
// Package for the keyframe clip player: item types, phase and action codes,
// controller command and status groups. No dependencies.
package kcp_pkg;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_PLAY   = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;
	localparam logic [1:0] KIND_TICK   = 2'd3;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PLAY    = 2'd1;
	localparam logic [1:0] PH_RECOVER = 2'd2;

	localparam logic [2:0] CFG_OWNER    = 3'd0;
	localparam logic [2:0] CFG_CLIP     = 3'd1;
	localparam logic [2:0] CFG_DURATION = 3'd2;
	localparam logic [2:0] CFG_RECOVERY = 3'd3;
	localparam logic [2:0] CFG_KF_TOTAL = 3'd4;

	// action chosen for a captured item
	localparam logic [3:0] ACT_NONE         = 4'd0;
	localparam logic [3:0] ACT_LOAD         = 4'd1;
	localparam logic [3:0] ACT_PLAY         = 4'd2;
	localparam logic [3:0] ACT_CANCEL_START = 4'd3;
	localparam logic [3:0] ACT_CANCEL_NOP   = 4'd4;
	localparam logic [3:0] ACT_RELEASE      = 4'd5;
	localparam logic [3:0] ACT_FINISH       = 4'd6;
	localparam logic [3:0] ACT_SCAN         = 4'd7;
	localparam logic [3:0] ACT_RECOVER      = 4'd8;

	typedef struct packed {
		logic [3:0] anchor;
		logic [3:0] direction;
		logic [7:0] focus;
		logic [7:0] lid;
	} pose_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now_ms;
		logic [3:0]  key_slot;
		logic [15:0] key_offset_ms;
		logic [3:0]  pose_anchor;
		logic [3:0]  pose_direction;
		logic [7:0]  pose_focus;
		logic [7:0]  pose_lid;
		logic        permit;
	} in_item_t;

	typedef struct packed {
		logic       accepted;
		logic [1:0] write_count;
		logic [3:0] out_anchor;
		logic [3:0] out_direction;
		logic [6:0] out_focus;
		logic [6:0] out_lid;
		logic       layer_freed;
		logic [1:0] phase;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic commit;
		logic scan_clr;
		logic scan_next;
		logic scan_chk;
		logic div_start;
		logic div_lane;
	} cmd_t;

	typedef struct packed {
		logic [3:0] act;
		logic       rec_done;
		logic       scan_stop;
		logic       div_done;
		logic       out_free;
	} status_t;

endpackage

@@ src/kcp_in_if.sv @@
// Input channel of the keyframe clip player: valid, ready and one item.
// Depends on kcp_pkg.
interface kcp_in_if;
	import kcp_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/kcp_out_if.sv @@
// Result channel of the keyframe clip player: valid, ready and one item.
// Depends on kcp_pkg.
interface kcp_out_if;
	import kcp_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/kcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/kcp_div.sv @@
// Restoring divider, one quotient bit per cycle: 24-bit dividend, 16-bit divisor.
// Depends on kcp_pkg for nothing; standalone.
module kcp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [23:0] quotient
);
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [23:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] rem_sh;
	logic [16:0] diff;

	assign rem_sh = {rem_q, quo_q[23]};
	assign diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= rem_sh[15:0];
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

@@ src/kcp_ctrl.sv @@
// Controller state machine: sequences capture, keyframe scan, blend divisions
// and commit of each item. Depends on kcp_pkg.
module kcp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  kcp_pkg::status_t st,
	output kcp_pkg::cmd_t    cmd
);
	import kcp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EVAL  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_DIV0  = 4'd4;
	localparam logic [3:0] S_WAIT0 = 4'd5;
	localparam logic [3:0] S_DIV1  = 4'd6;
	localparam logic [3:0] S_WAIT1 = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				case (st.act)
					ACT_PLAY, ACT_SCAN: begin
						cmd.scan_clr = 1'b1;
						state_d = S_RD;
					end
					ACT_RECOVER: state_d = st.rec_done ? S_DONE : S_DIV0;
					default: state_d = S_DONE;
				endcase
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				cmd.scan_chk = 1'b1;
				if (st.scan_stop) begin
					state_d = S_DONE;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = S_RD;
				end
			end
			S_DIV0: begin
				cmd.div_start = 1'b1;
				state_d = S_WAIT0;
			end
			S_WAIT0: if (st.div_done) state_d = S_DIV1;
			S_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_lane = 1'b1;
				state_d = S_WAIT1;
			end
			S_WAIT1: if (st.div_done) state_d = S_DONE;
			S_DONE: begin
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ src/kcp_datapath.sv @@
// Datapath: configuration and play state, keyframe table, scan selection,
// blend arithmetic and the result register. Depends on kcp_pkg, kcp_ram, kcp_div.
module kcp_datapath #(
	parameter int MAX_KEYFRAMES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  kcp_pkg::in_item_t   in_data,
	input  logic                out_ready,
	output logic                out_valid,
	output kcp_pkg::out_item_t  out_data,
	input  kcp_pkg::cmd_t       cmd,
	output kcp_pkg::status_t    st
);
	import kcp_pkg::*;

	localparam int IW = MAX_KEYFRAMES > 1 ? $clog2(MAX_KEYFRAMES) : 1;
	localparam int CW = $clog2(MAX_KEYFRAMES + 1);

	logic [15:0] owner_q, clip_q, dur_q, rec_q;
	logic [4:0]  kf_total_q;
	logic [1:0]  phase_q;
	logic        active_q;
	logic [31:0] start_q, rs_q;
	logic [32:0] re_q;
	pose_t       base_q;
	logic [7:0]  bf_focus_q, bf_lid_q;
	in_item_t    in_q;
	logic [IW-1:0] idx_q;
	pose_t       sel_q;
	logic        lane_q;
	logic [7:0]  res_q [2];
	out_item_t   out_q;
	logic        out_valid_q;

	logic [CW-1:0] fcnt;
	logic [3:0]    act;
	logic [31:0]   elapsed, scan_el;
	logic          slot_ok;
	logic [39:0]   rdata;
	pose_t         cur, rd_pose;
	logic [15:0]   rd_off;
	logic          scan_last;
	logic [15:0]   rt_eff, den;
	logic [31:0]   num;
	logic          num_ge;
	logic [7:0]    l_from, l_to, l_mag;
	logic [23:0]   prod;
	logic          div_done;
	logic [23:0]   quo;
	logic signed [10:0] v;
	logic [7:0]    blended;

	function automatic logic [6:0] pct(input logic [7:0] x);
		return (x > 8'd100) ? 7'd100 : x[6:0];
	endfunction

	assign cur = '{anchor: in_q.pose_anchor, direction: in_q.pose_direction,
		focus: in_q.pose_focus, lid: in_q.pose_lid};
	assign fcnt = (int'(kf_total_q) > MAX_KEYFRAMES) ? CW'(MAX_KEYFRAMES) : CW'(kf_total_q);
	assign slot_ok = int'(in_q.key_slot) < MAX_KEYFRAMES;
	assign elapsed = in_q.now_ms - start_q;

	always_comb begin
		act = ACT_NONE;
		case (in_q.kind)
			KIND_LOAD: if (slot_ok) act = ACT_LOAD;
			KIND_PLAY: begin
				if (owner_q != 16'd0 && clip_q != 16'd0 && fcnt != '0 && dur_q != 16'd0
						&& in_q.permit) act = ACT_PLAY;
			end
			KIND_CANCEL: begin
				if (active_q) act = (phase_q != PH_RECOVER) ? ACT_CANCEL_START : ACT_CANCEL_NOP;
			end
			default: begin
				if (active_q && owner_q != 16'd0) begin
					if (!in_q.permit) begin
						act = ACT_RELEASE;
					end else if (phase_q == PH_PLAY) begin
						if (in_q.now_ms < start_q || elapsed >= {16'd0, dur_q}) act = ACT_FINISH;
						else if (fcnt != '0) act = ACT_SCAN;
					end else if (phase_q == PH_RECOVER) begin
						act = ACT_RECOVER;
					end
				end
			end
		endcase
	end

	kcp_ram #(.WIDTH(40), .DEPTH(MAX_KEYFRAMES)) u_table (
		.clk   (clk),
		.we    (cmd.commit && act == ACT_LOAD),
		.waddr (IW'(in_q.key_slot)),
		.wdata ({in_q.key_offset_ms, cur}),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign rd_off = rdata[39:24];
	assign rd_pose = rdata[23:0];
	assign scan_el = (act == ACT_PLAY) ? 32'd0 : elapsed;
	assign scan_last = (CW'(idx_q) + CW'(1)) == fcnt;

	// blend of one lane: from + (to - from) * num / den, truncated toward zero
	assign rt_eff = (rec_q == 16'd0) ? 16'd1 : rec_q;
	assign den = re_q[15:0] - rs_q[15:0];
	assign num = (in_q.now_ms <= rs_q) ? 32'd0 : in_q.now_ms - rs_q;
	assign num_ge = num >= {16'd0, den};
	assign l_from = lane_q ? bf_lid_q : bf_focus_q;
	assign l_to = lane_q ? base_q.lid : base_q.focus;

	logic [7:0] s_from, s_to;
	assign s_from = cmd.div_lane ? bf_lid_q : bf_focus_q;
	assign s_to = cmd.div_lane ? base_q.lid : base_q.focus;
	assign l_mag = (s_to >= s_from) ? s_to - s_from : s_from - s_to;
	assign prod = l_mag * num[15:0];

	kcp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod),
		.divisor  (den),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		if (l_to >= l_from) v = $signed({3'd0, l_from}) + $signed({3'd0, quo[7:0]});
		else v = $signed({3'd0, l_from}) - $signed({3'd0, quo[7:0]});
		if (num_ge) blended = l_to;
		else if (v < 0) blended = 8'd0;
		else if (v > 11'sd100) blended = 8'd100;
		else blended = v[7:0];
	end

	assign st.act = act;
	assign st.rec_done = {1'b0, in_q.now_ms} >= re_q;
	assign st.scan_stop = ({16'd0, rd_off} > scan_el) || scan_last;
	assign st.div_done = div_done;
	assign st.out_free = !out_valid_q || out_ready;

	// commit: result item and next play state
	out_item_t res;
	pose_t     w;
	logic      go_idle, start_rec;
	always_comb begin
		res = '0;
		w = '0;
		go_idle = 1'b0;
		start_rec = 1'b0;
		case (act)
			ACT_LOAD: res.accepted = 1'b1;
			ACT_PLAY, ACT_SCAN: begin
				res.accepted = 1'b1;
				res.write_count = 2'd1;
				w = sel_q;
			end
			ACT_CANCEL_START, ACT_FINISH: begin
				res.accepted = 1'b1;
				start_rec = 1'b1;
			end
			ACT_CANCEL_NOP: res.accepted = 1'b1;
			ACT_RELEASE: begin
				res.layer_freed = 1'b1;
				go_idle = 1'b1;
			end
			ACT_RECOVER: begin
				res.accepted = 1'b1;
				if (st.rec_done) begin
					res.write_count = 2'd2;
					w = base_q;
					res.layer_freed = 1'b1;
					go_idle = 1'b1;
				end else begin
					res.write_count = 2'd1;
					w = '{anchor: base_q.anchor, direction: base_q.direction,
						focus: res_q[0], lid: res_q[1]};
				end
			end
			default: res = '0;
		endcase
		res.out_anchor = w.anchor;
		res.out_direction = w.direction;
		res.out_focus = pct(w.focus);
		res.out_lid = pct(w.lid);
		if (go_idle) res.phase = PH_IDLE;
		else if (act == ACT_PLAY) res.phase = PH_PLAY;
		else if (start_rec) res.phase = PH_RECOVER;
		else res.phase = phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
			clip_q <= '0;
			dur_q <= '0;
			rec_q <= '0;
			kf_total_q <= '0;
			phase_q <= PH_IDLE;
			active_q <= 1'b0;
			start_q <= '0;
			rs_q <= '0;
			re_q <= '0;
			base_q <= '0;
			bf_focus_q <= '0;
			bf_lid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OWNER:    owner_q <= cfg_data;
					CFG_CLIP:     clip_q <= cfg_data;
					CFG_DURATION: dur_q <= cfg_data;
					CFG_RECOVERY: rec_q <= cfg_data;
					CFG_KF_TOTAL: kf_total_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				phase_q <= res.phase;
				if (act == ACT_PLAY) begin
					active_q <= 1'b1;
					start_q <= in_q.now_ms;
					rs_q <= '0;
					re_q <= '0;
					base_q <= cur;
				end
				if (start_rec) begin
					bf_focus_q <= in_q.pose_focus;
					bf_lid_q <= in_q.pose_lid;
					rs_q <= in_q.now_ms;
					re_q <= {1'b0, in_q.now_ms} + {17'd0, rt_eff};
				end
				if (go_idle) begin
					active_q <= 1'b0;
					start_q <= '0;
					rs_q <= '0;
					re_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= in_data;
		if (cmd.scan_clr) idx_q <= '0;
		else if (cmd.scan_next) idx_q <= idx_q + IW'(1);
		if (cmd.scan_chk && (idx_q == '0 || {16'd0, rd_off} <= scan_el)) sel_q <= rd_pose;
		if (cmd.div_start) lane_q <= cmd.div_lane;
		if (div_done) res_q[lane_q] <= blended;
		if (cmd.commit) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

@@ src/keyframe_clip_player_unit.sv @@
// Keyframe clip player, top level: controller and datapath.
// Depends on kcp_pkg, kcp_in_if, kcp_out_if, kcp_ctrl, kcp_datapath.
//
// Use: items enter on req (valid/ready), one result item per input item
// leaves on rsp (valid/ready). Registers are written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// One item at a time: req.ready is high only while the controller waits.
// Steps from capture to the result register:
//   load, cancel, refused items: evaluation, then commit
//   play or playing tick: sequential keyframe table reads through the
//     registered RAM port, at most MAX_KEYFRAMES keyframes scanned
//   recovering tick: the two serial blend divisions (a start state and a
//     wait state each, for 24 quotient bits), none on the finishing tick.
// A result sits in the output register until rsp.ready; while it waits the
// next item is accepted and worked, and its commit holds until the register
// frees. Reset clears the configuration registers, play state and the output
// valid flag; the keyframe table keeps no reset and must be loaded before it is played.
module keyframe_clip_player_unit #(
	parameter int MAX_KEYFRAMES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	kcp_in_if.sink      req,
	kcp_out_if.source   rsp
);
	import kcp_pkg::*;

	cmd_t    cmd;
	status_t st;

	kcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	kcp_datapath #(.MAX_KEYFRAMES(MAX_KEYFRAMES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (req.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.data),
		.cmd       (cmd),
		.st        (st)
	);
endmodule

@@ test/tb_keyframe_clip_player_unit.sv @@
// Testbench for keyframe_clip_player_unit: directed table then random clips,
// every result checked against an in-bench clip player predictor.
// Depends on kcp_pkg, kcp_in_if, kcp_out_if and the RTL top level.
`timescale 1ns / 1ps

module tb_keyframe_clip_player_unit;
	import kcp_pkg::*;

	localparam int NFRAMES   = 16;
	localparam int LAT_PAUSE = 80;
	localparam int WD_LIMIT  = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_OWNER;
	logic [15:0] cfg_data = '0;

	kcp_in_if  req ();
	kcp_out_if rsp ();

	keyframe_clip_player_unit #(.MAX_KEYFRAMES(NFRAMES)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [15:0] owner_r, clip_r, dur_r, rec_r;
	logic [4:0]  total_r;
	logic [1:0]  phase_s;
	logic        active_s;
	logic [31:0] start_s, rec_start_s;
	logic [32:0] rec_end_s;
	pose_t       base_s;
	logic [7:0]  from_focus_s, from_lid_s;
	logic [15:0] kf_off [NFRAMES];
	pose_t       kf_pose [NFRAMES];

	out_item_t pose_queue [$];
	int        errors = 0;
	int        n_items = 0, n_results = 0, n_release = 0, n_finish = 0;
	int        stall_cycles = 0;
	bit        calm = 1'b0;

	typedef struct {
		bit        is_cfg;
		logic [2:0] idx;
		logic [15:0] val;
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} row_t;
	row_t rows [$];

	function automatic logic [7:0] blend_to(logic [7:0] from, logic [7:0] to,
			longint unsigned num, longint unsigned den);
		int v;
		if (den == 0 || num >= den) return to;
		v = int'(from) + ((int'(to) - int'(from)) * int'(num)) / int'(den);
		if (v < 0) v = 0;
		if (v > 100) v = 100;
		return v[7:0];
	endfunction

	function automatic int pick_frame(longint unsigned elapsed);
		int n, sel;
		n = (total_r > NFRAMES) ? NFRAMES : int'(total_r);
		if (n == 0) return -1;
		sel = 0;
		for (int i = 0; i < n; i++) begin
			if (longint'(kf_off[i]) <= elapsed) sel = i;
			else break;
		end
		return sel;
	endfunction

	function automatic void enter_recovery(logic [31:0] now, pose_t cur);
		from_focus_s = cur.focus;
		from_lid_s = cur.lid;
		rec_start_s = now;
		rec_end_s = {1'b0, now} + ((rec_r == 0) ? 33'd1 : {17'd0, rec_r});
		phase_s = PH_RECOVER;
	endfunction

	function automatic void clip_idle();
		active_s = 1'b0;
		phase_s = PH_IDLE;
		start_s = '0;
		rec_start_s = '0;
		rec_end_s = '0;
	endfunction

	function automatic out_item_t predict_pose(in_item_t it);
		out_item_t o;
		pose_t cur, w;
		int k;
		longint unsigned num, den;
		logic [1:0] wr;
		o = '0;
		w = '0;
		wr = 2'd0;
		cur = '{it.pose_anchor, it.pose_direction, it.pose_focus, it.pose_lid};
		case (it.kind)
			KIND_LOAD: begin
				kf_off[it.key_slot] = it.key_offset_ms;
				kf_pose[it.key_slot] = cur;
				o.accepted = 1'b1;
			end
			KIND_PLAY: begin
				if (owner_r != 0 && clip_r != 0 && total_r != 0 && dur_r != 0 && it.permit) begin
					active_s = 1'b1;
					phase_s = PH_PLAY;
					start_s = it.now_ms;
					rec_start_s = '0;
					rec_end_s = '0;
					base_s = cur;
					k = pick_frame(0);
					w = kf_pose[k];
					wr = 2'd1;
					o.accepted = 1'b1;
				end
			end
			KIND_CANCEL: begin
				if (active_s) begin
					o.accepted = 1'b1;
					if (phase_s != PH_RECOVER) enter_recovery(it.now_ms, cur);
				end
			end
			default: begin
				if (active_s && owner_r != 0) begin
					if (!it.permit) begin
						clip_idle();
						o.layer_freed = 1'b1;
					end else if (phase_s == PH_PLAY) begin
						if (it.now_ms < start_s || (it.now_ms - start_s) >= dur_r) begin
							enter_recovery(it.now_ms, cur);
							o.accepted = 1'b1;
						end else begin
							k = pick_frame(longint'(it.now_ms - start_s));
							if (k >= 0) begin
								w = kf_pose[k];
								wr = 2'd1;
								o.accepted = 1'b1;
							end
						end
					end else if (phase_s == PH_RECOVER) begin
						den = longint'(rec_end_s) - longint'(rec_start_s);
						num = (it.now_ms <= rec_start_s) ? 0 : longint'(it.now_ms - rec_start_s);
						w.anchor = base_s.anchor;
						w.direction = base_s.direction;
						w.focus = blend_to(from_focus_s, base_s.focus, num, den);
						w.lid = blend_to(from_lid_s, base_s.lid, num, den);
						wr = 2'd1;
						if ({1'b0, it.now_ms} >= rec_end_s) begin
							w = base_s;
							wr = 2'd2;
							clip_idle();
							o.layer_freed = 1'b1;
						end
						o.accepted = 1'b1;
					end
				end
			end
		endcase
		o.write_count = wr;
		if (wr != 0) begin
			o.out_anchor = w.anchor;
			o.out_direction = w.direction;
			o.out_focus = (w.focus > 100) ? 7'd100 : w.focus[6:0];
			o.out_lid = (w.lid > 100) ? 7'd100 : w.lid[6:0];
		end
		o.phase = phase_s;
		return o;
	endfunction

	// acceptance, checking, result-side stalls, watchdog
	always @(posedge clk) begin
		out_item_t want, got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (req.valid && req.ready) begin
				pose_queue.push_back(predict_pose(req.data));
				n_items <= n_items + 1;
				moved = 1'b1;
			end
			if (rsp.valid && rsp.ready) begin
				moved = 1'b1;
				got = rsp.data;
				n_results <= n_results + 1;
				if (got.layer_freed) n_release <= n_release + 1;
				if (got.write_count == 2) n_finish <= n_finish + 1;
				if (pose_queue.size() == 0) begin
					$display("%0t: mismatch expected nothing actual %p", $time, got);
					errors++;
				end else begin
					want = pose_queue.pop_front();
					if (want !== got) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, got);
						errors++;
					end
				end
			end
			if (moved) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			rsp.ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	// valid stays high after acceptance; drain() lowers it, and the next call may lower it for a random pause
	task automatic send_item(in_item_t it);
		while (!calm && $urandom_range(99) < 6) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= it;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pose_queue.size() != 0) @(posedge clk);
		repeat (LAT_PAUSE) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_OWNER:    owner_r = val;
			CFG_CLIP:     clip_r = val;
			CFG_DURATION: dur_r = val;
			CFG_RECOVERY: rec_r = val;
			default:      total_r = val[4:0];
		endcase
		@(posedge clk);
	endtask

	function automatic in_item_t mk(logic [1:0] kind, logic [31:0] now, logic [3:0] slot,
			logic [15:0] off, logic [3:0] a, logic [3:0] d, logic [7:0] f, logic [7:0] l,
			logic p);
		return '{kind, now, slot, off, a, d, f, l, p};
	endfunction

	function automatic void add_item(in_item_t it, bit typed = 0, out_item_t want = '0);
		row_t r;
		r.is_cfg = 0; r.idx = CFG_OWNER; r.val = '0;
		r.item = it; r.typed = typed; r.want = want;
		rows.push_back(r);
	endfunction

	function automatic void add_cfg(logic [2:0] idx, logic [15:0] val);
		row_t r;
		r.is_cfg = 1; r.idx = idx; r.val = val;
		r.item = '0; r.typed = 0; r.want = '0;
		rows.push_back(r);
	endfunction

	function automatic in_item_t rand_item(ref logic [31:0] clock_ms);
		in_item_t it;
		int pick;
		it = '0;
		it.now_ms = $urandom;
		it.key_slot = 4'($urandom_range(15));
		it.key_offset_ms = 16'($urandom);
		it.pose_anchor = 4'($urandom_range(15));
		it.pose_direction = 4'($urandom_range(15));
		it.pose_focus = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(100));
		it.pose_lid = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(100));
		it.permit = ($urandom_range(99) >= 4);
		pick = $urandom_range(99);
		if (pick < 80) begin
			// coherent clip timeline
			clock_ms += $urandom_range(40);
			it.now_ms = clock_ms;
			if (pick < 6) it.kind = KIND_PLAY;
			else if (pick < 10) it.kind = KIND_CANCEL;
			else if (pick < 14) begin
				it.kind = KIND_LOAD;
				it.key_offset_ms = 16'(it.key_slot * $urandom_range(40));
			end else it.kind = KIND_TICK;
		end else begin
			it.kind = 2'($urandom_range(3));
			if (pick < 84) it.now_ms = clock_ms - $urandom_range(50);
		end
		return it;
	endfunction

	initial begin
		logic [31:0] clock_ms;
		out_item_t z, ld, rl;
		row_t r;
		in_item_t it;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		owner_r = '0; clip_r = '0; dur_r = '0; rec_r = '0; total_r = '0;
		clip_idle();
		base_s = '0; from_focus_s = '0; from_lid_s = '0;
		for (int i = 0; i < NFRAMES; i++) begin
			kf_off[i] = '0;
			kf_pose[i] = '0;
		end

		z = '0;
		ld = '0; ld.accepted = 1'b1;
		rl = '0; rl.layer_freed = 1'b1;
		// idle block with all registers zero
		add_item(mk(KIND_TICK, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 4'hF, 4'hF, 8'hFF, 8'hFF, 1), 1, z);
		add_item(mk(KIND_CANCEL, 0, 0, 0, 0, 0, 0, 0, 1), 1, z);
		add_item(mk(KIND_PLAY, 100, 0, 0, 1, 2, 3, 4, 1), 1, z);
		for (int i = 0; i < NFRAMES; i++)
			add_item(mk(KIND_LOAD, $urandom, 4'(i), 16'(i * 50), 4'(i), 4'(15 - i),
				8'(i * 17), 8'(255 - i * 17), 1'(i)), 1, ld);
		add_cfg(CFG_OWNER, 16'hFFFF);
		add_cfg(CFG_CLIP, 16'd1);
		add_cfg(CFG_DURATION, 16'd400);
		add_cfg(CFG_RECOVERY, 16'd0);
		add_cfg(CFG_KF_TOTAL, 16'd31);
		add_item(mk(KIND_PLAY, 1000, 0, 0, 3, 4, 90, 20, 0), 1, z);
		add_item(mk(KIND_PLAY, 1000, 0, 0, 3, 4, 90, 20, 1));
		add_item(mk(KIND_TICK, 1120, 0, 0, 0, 0, 0, 0, 1));
		add_item(mk(KIND_TICK, 999, 0, 0, 0, 0, 200, 255, 1));
		add_item(mk(KIND_TICK, 1001, 0, 0, 0, 0, 0, 0, 1));
		add_item(mk(KIND_PLAY, 2000, 0, 0, 5, 6, 255, 0, 1));
		add_item(mk(KIND_TICK, 2399, 0, 0, 0, 0, 0, 0, 1));
		add_item(mk(KIND_CANCEL, 2399, 0, 0, 0, 0, 0, 100, 1));
		add_item(mk(KIND_CANCEL, 2399, 0, 0, 0, 0, 0, 100, 1));
		add_item(mk(KIND_TICK, 2400, 0, 0, 0, 0, 0, 0, 1));
		add_item(mk(KIND_PLAY, 3000, 0, 0, 5, 6, 50, 50, 1));
		add_item(mk(KIND_TICK, 3010, 0, 0, 0, 0, 0, 0, 0), 1, rl);

		foreach (rows[i]) ;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (rows.size() != 0) begin
			r = rows.pop_front();
			if (r.is_cfg) begin
				drain();
				write_reg(r.idx, r.val);
			end else if (r.typed) begin
				// typed rows: compare the predictor against the hand value too
				send_item(r.item);
				@(posedge clk);
				if (pose_queue.size() != 0 && pose_queue[$] !== r.want) begin
					$display("%0t: mismatch expected %p actual %p", $time, r.want, pose_queue[$]);
					errors++;
				end
			end else send_item(r.item);
		end

		clock_ms = 32'd5000;
		for (int ph = 0; ph < 11; ph++) begin
			drain();
			write_reg(CFG_OWNER, (ph == 3) ? 16'd0 : ((ph % 2) ? 16'hFFFF : 16'($urandom_range(1, 65535))));
			write_reg(CFG_CLIP, (ph == 5) ? 16'd0 : ((ph == 6) ? 16'hFFFF : 16'($urandom_range(1, 65535))));
			write_reg(CFG_DURATION, (ph == 7) ? 16'd0 : ((ph == 8) ? 16'hFFFF : 16'($urandom_range(1, 300))));
			write_reg(CFG_RECOVERY, (ph == 2) ? 16'hFFFF : ((ph % 3 == 0) ? 16'd0 : 16'($urandom_range(1, 120))));
			write_reg(CFG_KF_TOTAL, (ph == 4) ? 16'd0 : ((ph == 9) ? 16'd31 : 16'($urandom_range(1, 16))));
			calm = (ph == 6);
			for (int j = 0; j < 50; j++) begin
				it = rand_item(clock_ms);
				send_item(it);
			end
		end
		calm = 1'b0;
		drain();

		$display("run: %0d items, %0d results, %0d releases, %0d finished recoveries",
			n_items, n_results, n_release, n_finish);
		$display("covered refused plays, cancels, permit loss, early time and blend-back");
		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (stall_cycles >= WD_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

endmodule
